// File: sv/nps_pkg.sv
// Shared types and codes for the nearest point search block.
package nps_pkg;

	// Operation codes
	localparam logic [1:0] OP_INSERT = 2'd0;
	localparam logic [1:0] OP_QUERY  = 2'd1;
	localparam logic [1:0] OP_CLEAR  = 2'd2;

	// Status codes
	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_FULL  = 2'd1;
	localparam logic [1:0] ST_EMPTY = 2'd2;

	// Squared distance of two Q8.8 points fits in 33 bits
	localparam int DIST_W = 33;
	localparam int SQ_W   = 32;

	// Stored point, x in the low half
	typedef struct packed {
		logic signed [15:0] y;
		logic signed [15:0] x;
	} point_t;

	typedef struct packed {
		logic [1:0]         operation;
		logic signed [15:0] point_x;
		logic signed [15:0] point_y;
	} req_t;

	typedef struct packed {
		logic signed [15:0] nearest_x;
		logic signed [15:0] nearest_y;
		logic [7:0]         nearest_index;
		logic [8:0]         stored_count;
		logic [1:0]         status;
	} rsp_t;

endpackage

// File: sv/nps_store.sv
// Point table: one write port, one registered read port.
module nps_store
	import nps_pkg::*;
#(
	parameter int DEPTH = 256,
	parameter int AW    = 8
) (
	input  logic          clk,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  point_t        wr_data,
	input  logic          rd_en,
	input  logic [AW-1:0] rd_addr,
	output point_t        rd_data
);

	point_t mem_q [DEPTH];
	point_t rd_data_q;

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// File: sv/nps_dist.sv
// Shared squared-distance unit: difference, square, sum over three stages.
module nps_dist
	import nps_pkg::*;
#(
	parameter int IW = 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic              in_last,
	input  logic [IW-1:0]     in_index,
	input  point_t            in_point,
	input  point_t            query,
	output logic              out_valid,
	output logic              out_last,
	output logic [IW-1:0]     out_index,
	output point_t            out_point,
	output logic [DIST_W-1:0] out_dist
);

	logic                     valid_s1, valid_s2, valid_s3;
	logic                     last_s1, last_s2, last_s3;
	logic [IW-1:0]            idx_s1, idx_s2, idx_s3;
	point_t                   pt_s1, pt_s2, pt_s3;
	logic signed [16:0]       dx_s1, dy_s1;
	logic [SQ_W-1:0]          sqx_s2, sqy_s2;
	logic [DIST_W-1:0]        dist_s3;
	logic signed [33:0]       prod_x, prod_y;

	// squares are nonnegative and below 2^32
	assign prod_x = dx_s1 * dx_s1;
	assign prod_y = dy_s1 * dy_s1;

	// valid and last tags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			last_s1  <= 1'b0;
			last_s2  <= 1'b0;
			last_s3  <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			last_s1  <= in_valid & in_last;
			last_s2  <= last_s1;
			last_s3  <= last_s2;
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		dx_s1   <= {in_point.x[15], in_point.x} - {query.x[15], query.x};
		dy_s1   <= {in_point.y[15], in_point.y} - {query.y[15], query.y};
		idx_s1  <= in_index;
		pt_s1   <= in_point;
		sqx_s2  <= prod_x[SQ_W-1:0];
		sqy_s2  <= prod_y[SQ_W-1:0];
		idx_s2  <= idx_s1;
		pt_s2   <= pt_s1;
		dist_s3 <= {1'b0, sqx_s2} + {1'b0, sqy_s2};
		idx_s3  <= idx_s2;
		pt_s3   <= pt_s2;
	end

	assign out_valid = valid_s3;
	assign out_last  = last_s3;
	assign out_index = idx_s3;
	assign out_point = pt_s3;
	assign out_dist  = dist_s3;

endmodule

// File: sv/nearest_point_search.sv
// Top level: command sequencer, point table and nearest-point scan.
//
//   channel   handshake         payload   transfer when
//   request   start / busy      req_t     start high and busy low at clk edge
//   result    done (strobe)     rsp_t     done high for one cycle, no stall
//
// Insert, clear and unused codes: result in the cycle after the transfer, busy stays low.
// Query: on an empty table as above; else the scan reads every stored point, and the single
// distance unit takes one stored point per cycle from the table's one read port; the read
// and the distance stages are registered before the running best gives the result.
// Reset empties the table at once; no clearing pass. The receiver cannot stall.
module nearest_point_search
	import nps_pkg::*;
#(
	parameter int CAPACITY = 256
) (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  req_t request,
	output logic done,
	output rsp_t result
);

	localparam int IW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);

	typedef enum logic [1:0] {S_IDLE, S_SCAN, S_DRAIN} state_t;

	state_t            state_q;
	logic [CW-1:0]     count_q;
	logic [IW-1:0]     iss_q;
	point_t            query_q;
	logic              done_q;
	rsp_t              result_q;
	logic [DIST_W-1:0] best_d_q;
	logic [IW-1:0]     best_idx_q;
	point_t            best_pt_q;
	logic              rd_valid_s1, rd_last_s1;
	logic [IW-1:0]     rd_idx_s1;

	logic              accept, not_full, wr_en, rd_en, iss_last;
	point_t            wr_pt, rd_pt;
	logic              d_valid, d_last, take;
	logic [IW-1:0]     d_idx, sel_idx;
	point_t            d_pt, sel_pt;
	logic [DIST_W-1:0] d_dist;

	assign accept   = start & (state_q == S_IDLE);
	assign not_full = count_q < CW'(CAPACITY);
	assign wr_en    = accept & (request.operation == OP_INSERT) & not_full;
	assign wr_pt    = '{y: request.point_y, x: request.point_x};
	assign rd_en    = (state_q == S_SCAN);
	assign iss_last = CW'(iss_q) == (count_q - CW'(1));

	nps_store #(.DEPTH(CAPACITY), .AW(IW)) u_store (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (count_q[IW-1:0]),
		.wr_data (wr_pt),
		.rd_en   (rd_en),
		.rd_addr (iss_q),
		.rd_data (rd_pt)
	);

	// tags that follow the table read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_valid_s1 <= 1'b0;
			rd_last_s1  <= 1'b0;
		end else begin
			rd_valid_s1 <= rd_en;
			rd_last_s1  <= rd_en & iss_last;
		end
	end

	always_ff @(posedge clk) begin
		rd_idx_s1 <= iss_q;
	end

	nps_dist #(.IW(IW)) u_dist (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (rd_valid_s1),
		.in_last   (rd_last_s1),
		.in_index  (rd_idx_s1),
		.in_point  (rd_pt),
		.query     (query_q),
		.out_valid (d_valid),
		.out_last  (d_last),
		.out_index (d_idx),
		.out_point (d_pt),
		.out_dist  (d_dist)
	);

	// later index wins on a tie
	assign take    = d_dist <= best_d_q;
	assign sel_idx = take ? d_idx : best_idx_q;
	assign sel_pt  = take ? d_pt : best_pt_q;

	// sequencer, running best and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			count_q    <= '0;
			iss_q      <= '0;
			done_q     <= 1'b0;
			query_q    <= '0;
			result_q   <= '0;
			best_d_q   <= '1;
			best_idx_q <= '0;
			best_pt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (d_valid && take) begin
				best_d_q   <= d_dist;
				best_idx_q <= d_idx;
				best_pt_q  <= d_pt;
			end
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						done_q   <= 1'b1;
						result_q <= '0;
						unique case (request.operation)
							OP_INSERT: begin
								if (not_full) begin
									count_q                 <= count_q + CW'(1);
									result_q.stored_count   <= 9'(count_q + CW'(1));
									result_q.status         <= ST_OK;
								end else begin
									result_q.stored_count   <= 9'(count_q);
									result_q.status         <= ST_FULL;
								end
							end
							OP_QUERY: begin
								result_q.stored_count <= 9'(count_q);
								if (count_q == '0) begin
									result_q.status <= ST_EMPTY;
								end else begin
									done_q     <= 1'b0;
									state_q    <= S_SCAN;
									iss_q      <= '0;
									query_q    <= wr_pt;
									best_d_q   <= '1;
								end
							end
							OP_CLEAR: begin
								count_q <= '0;
							end
							default: begin
								result_q.stored_count <= 9'(count_q);
							end
						endcase
					end
				end
				S_SCAN: begin
					iss_q <= iss_q + IW'(1);
					if (iss_last) begin
						state_q <= S_DRAIN;
					end
				end
				S_DRAIN: begin
					if (d_valid && d_last) begin
						done_q                 <= 1'b1;
						state_q                <= S_IDLE;
						result_q.nearest_x     <= sel_pt.x;
						result_q.nearest_y     <= sel_pt.y;
						result_q.nearest_index <= 8'(sel_idx);
						result_q.status        <= ST_OK;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign busy   = (state_q != S_IDLE);
	assign done   = done_q;
	assign result = result_q;

endmodule

// File: bench/nearest_point_search_tb.sv
// Self-checking testbench for nearest_point_search: insert, query, clear and unused codes.
module nearest_point_search_tb
	import nps_pkg::*;
;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int CAPACITY = 256;
	localparam int ITEM_TARGET = 850;
	// Code 3 has no name in the package; the block must ignore it
	localparam logic [1:0] OP_UNUSED = 2'd3;

	// Tracks the point table and the answers still owed by the block
	class point_table_tracker;
		point_t points[CAPACITY];
		int held;
		rsp_t answers_due[$];
		int mismatches;

		function new();
			held = 0;
			mismatches = 0;
		endfunction

		function longint sq_distance(point_t p, logic signed [15:0] qx,
				logic signed [15:0] qy);
			longint dx;
			longint dy;
			dx = longint'(p.x) - longint'(qx);
			dy = longint'(p.y) - longint'(qy);
			return dx * dx + dy * dy;
		endfunction

		// Update the table for one accepted command and queue its answer
		function void note_command(req_t cmd);
			rsp_t ans;
			longint best_d;
			longint d;
			int best;
			ans = '0;
			best = 0;
			case (cmd.operation)
				OP_INSERT: begin
					if (held < CAPACITY) begin
						points[held].x = cmd.point_x;
						points[held].y = cmd.point_y;
						held++;
					end else begin
						ans.status = ST_FULL;
					end
				end
				OP_QUERY: begin
					if (held == 0) begin
						ans.status = ST_EMPTY;
					end else begin
						// Linear scan, later index wins a tie
						best_d = sq_distance(points[0], cmd.point_x, cmd.point_y);
						for (int j = 0; j < held; j++) begin
							d = sq_distance(points[j], cmd.point_x, cmd.point_y);
							if (d <= best_d) begin
								best_d = d;
								best = j;
							end
						end
						ans.nearest_x = points[best].x;
						ans.nearest_y = points[best].y;
						ans.nearest_index = best[7:0];
					end
				end
				OP_CLEAR: held = 0;
				default: ;
			endcase
			ans.stored_count = held[8:0];
			answers_due = {answers_due, ans};
		endfunction

		function void report(string field, longint want, longint got);
			$display("%0t ns: %s expected %0d actual %0d", $time, field, want, got);
			mismatches++;
		endfunction

		// Compare one result transfer with the oldest answer owed
		function void check_answer(rsp_t got);
			rsp_t want;
			if (answers_due.size() == 0) begin
				$display("%0t ns: result with none expected, actual %p", $time, got);
				mismatches++;
				return;
			end
			want = answers_due.pop_front();
			if (got.nearest_x !== want.nearest_x)
				report("nearest_x", want.nearest_x, got.nearest_x);
			if (got.nearest_y !== want.nearest_y)
				report("nearest_y", want.nearest_y, got.nearest_y);
			if (got.nearest_index !== want.nearest_index)
				report("nearest_index", want.nearest_index, got.nearest_index);
			if (got.stored_count !== want.stored_count)
				report("stored_count", want.stored_count, got.stored_count);
			if (got.status !== want.status)
				report("status", want.status, got.status);
		endfunction

		// A stored point, or a random one on an empty table
		function point_t pick_stored();
			point_t p;
			if (held == 0) begin
				p = $urandom;
			end else begin
				p = points[$urandom_range(0, held - 1)];
			end
			return p;
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;
	logic start;
	logic busy;
	req_t request;
	logic done;
	rsp_t result;

	point_table_tracker tracker = new();
	int sent = 0;
	bit steady = 1'b0;

	nearest_point_search #(
		.CAPACITY(CAPACITY)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.request(request),
		.done(done),
		.result(result)
	);

	// 12 ns clock
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Result monitor
	always @(posedge clk) begin
		if (arst_n === 1'b1 && done === 1'b1)
			tracker.check_answer(result);
	end

	// Coordinate mix: extremes, a tight cluster for ties, full range
	function automatic logic [15:0] rand_coord();
		int r;
		logic [15:0] v;
		r = $urandom_range(0, 9);
		case (r)
			0, 1: begin
				case ($urandom_range(0, 3))
					0: v = 16'h8000;
					1: v = 16'h7fff;
					2: v = 16'h0000;
					default: v = 16'hffff;
				endcase
			end
			2, 3, 4: v = 16'($signed($urandom_range(0, 6)) - 3);
			default: v = 16'($urandom);
		endcase
		return v;
	endfunction

	// Hold one command until the block takes it
	task automatic send_command(input logic [1:0] op, input logic [15:0] x,
			input logic [15:0] y);
		@(negedge clk);
		start <= 1'b1;
		request <= '{operation: op, point_x: x, point_y: y};
		do @(posedge clk); while (busy !== 1'b0);
		tracker.note_command(request);
		sent++;
	endtask

	// Random idle between commands; garbage on the bus while start is low
	task automatic take_break();
		int r;
		int gap;
		logic [63:0] noise;
		if ($urandom_range(0, 49) == 0)
			steady = !steady;
		r = $urandom_range(0, 99);
		if (steady || r < 55)
			gap = 0;
		else if (r < 85)
			gap = $urandom_range(1, 3);
		else if (r < 97)
			gap = $urandom_range(4, 10);
		else
			gap = $urandom_range(20, 60);
		if (gap > 0) begin
			noise = {$urandom, $urandom};
			@(negedge clk);
			start <= 1'b0;
			request <= noise[$bits(req_t)-1:0];
			repeat (gap - 1) @(negedge clk);
		end
	endtask

	task automatic query_near_stored();
		point_t p;
		p = tracker.pick_stored();
		if ($urandom_range(0, 1) == 0) begin
			p.x = p.x + 16'($signed($urandom_range(0, 4)) - 2);
			p.y = p.y + 16'($signed($urandom_range(0, 4)) - 2);
		end
		send_command(OP_QUERY, p.x, p.y);
	endtask

	// Main stimulus
	initial begin
		int r;
		arst_n = 1'b0;
		start = 1'b0;
		request = '0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed: empty query, extremes, ties, unused code, clear
		send_command(OP_QUERY, 16'h0000, 16'h0000);
		send_command(OP_UNUSED, 16'h1234, 16'h8765);
		send_command(OP_INSERT, 16'h8000, 16'h8000);
		send_command(OP_INSERT, 16'h7fff, 16'h7fff);
		send_command(OP_INSERT, 16'h8000, 16'h7fff);
		send_command(OP_INSERT, 16'h7fff, 16'h8000);
		send_command(OP_INSERT, 16'h0000, 16'h0000);
		send_command(OP_QUERY, 16'h7fff, 16'h7fff);
		send_command(OP_QUERY, 16'h8000, 16'h8000);
		send_command(OP_QUERY, 16'h0000, 16'h0000);
		// Duplicate point: the later copy must win
		send_command(OP_INSERT, 16'h0000, 16'h0000);
		send_command(OP_QUERY, 16'h0000, 16'h0000);
		// Equidistant pair around (1,0)
		send_command(OP_INSERT, 16'h0002, 16'h0000);
		send_command(OP_QUERY, 16'h0001, 16'h0000);
		send_command(OP_QUERY, 16'hffff, 16'hffff);
		send_command(OP_UNUSED, 16'hffff, 16'h0000);
		send_command(OP_CLEAR, 16'h5555, 16'haaaa);
		send_command(OP_QUERY, 16'h7fff, 16'h8000);
		send_command(OP_INSERT, 16'hffff, 16'hffff);
		send_command(OP_QUERY, 16'h7fff, 16'h8000);
		send_command(OP_CLEAR, 16'h0000, 16'h0000);

		// Fill the table to capacity, then push past it
		while (tracker.held < CAPACITY) begin
			send_command(OP_INSERT, rand_coord(), rand_coord());
			if ($urandom_range(0, 31) == 0)
				query_near_stored();
			take_break();
		end
		repeat (4) begin
			send_command(OP_INSERT, rand_coord(), rand_coord());
			take_break();
		end
		send_command(OP_UNUSED, rand_coord(), rand_coord());
		repeat (8) begin
			if ($urandom_range(0, 2) == 0)
				send_command(OP_QUERY, rand_coord(), rand_coord());
			else
				query_near_stored();
			take_break();
		end
		send_command(OP_CLEAR, rand_coord(), rand_coord());

		// Mixed traffic with occasional clears
		while (sent < ITEM_TARGET) begin
			r = $urandom_range(0, 99);
			if (r < 50)
				send_command(OP_INSERT, rand_coord(), rand_coord());
			else if (r < 70)
				query_near_stored();
			else if (r < 90)
				send_command(OP_QUERY, rand_coord(), rand_coord());
			else if (r < 94)
				send_command(OP_CLEAR, rand_coord(), rand_coord());
			else
				send_command(OP_UNUSED, rand_coord(), rand_coord());
			take_break();
		end

		@(negedge clk);
		start <= 1'b0;
		while (tracker.answers_due.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		if (tracker.mismatches == 0 && tracker.answers_due.size() == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

	// Watchdog
	initial begin
		#20_000_000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
